// ===== hdl/assert_macros.svh =====
// assertion macros used by the deframer top module
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define SWFD_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("%m: check failed");

// consequent holds in the same cycle
`define SWFD_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: check failed");

// consequent holds in the next cycle
`define SWFD_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: check failed");

`endif

// ===== hdl/swfd_pkg.sv =====
// types and constants of the framed packet deframer
// no dependencies
package swfd_pkg;

  localparam int FRAME_LEN   = 15;
  localparam int PAYLOAD_LEN = 11;
  localparam int CELLS       = FRAME_LEN - 1;
  localparam int SUM_W       = 12;
  localparam int FILL_W      = 4;
  localparam int BAD_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_DATA_W  = 104;

  localparam logic [FILL_W-1:0] FILL_LAST  = FILL_W'(FRAME_LEN - 1);
  localparam logic [FILL_W-1:0] FILL_DROP2 = FILL_W'(FRAME_LEN - 2);

  localparam logic       OP_BYTE    = 1'b0;
  localparam logic       OP_TIMEOUT = 1'b1;

  localparam logic [1:0] KIND_GOOD    = 2'd0;
  localparam logic [1:0] KIND_BAD_SUM = 2'd1;
  localparam logic [1:0] KIND_FLUSH   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

  localparam logic [7:0] LIMIT_RESET = 8'd100;

  typedef logic [7:0]       byte_t;
  typedef logic [SUM_W-1:0] psum_t;
  typedef byte_t [CELLS-1:0] win_t;
  typedef psum_t [CELLS-1:0] sums_t;

  typedef struct packed {
    logic hdr_ok;
    logic tail_ok;
    logic sum_ok;
  } frame_chk_t;

  // packed from the top down, device_id ends up in the lowest bits
  typedef struct packed {
    logic [15:0] computed_checksum;
    logic [15:0] received_checksum;
    logic [31:0] timestamp;
    logic [7:0]  device_status;
    logic [15:0] parameter_res;
    logic [7:0]  command;
    logic [7:0]  device_id;
  } frame_fields_t;

endpackage

// ===== hdl/swfd_cell.sv =====
// one window cell: holds a byte and the running byte sum up to its position
// depends on swfd_pkg
module swfd_cell (
  input  logic           clk,
  input  logic           shift_en,
  input  swfd_pkg::byte_t byte_in,
  input  swfd_pkg::byte_t new_byte,
  input  swfd_pkg::psum_t sum_in,
  output swfd_pkg::byte_t byte_out,
  output swfd_pkg::psum_t sum_out
);
  import swfd_pkg::*;

  byte_t byte_r;
  psum_t sum_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
      sum_r  <= sum_in + psum_t'(new_byte);
    end
  end

  assign byte_out = byte_r;
  assign sum_out  = sum_r;

endmodule

// ===== hdl/swfd_frame_check.sv =====
// frame checks and field extraction on a full window
// depends on swfd_pkg; window cell 0 holds the newest stored byte
module swfd_frame_check (
  input  swfd_pkg::win_t          win,
  input  swfd_pkg::sums_t         sums,
  input  swfd_pkg::byte_t         rx_byte,
  input  logic [15:0]             header_word,
  input  logic [15:0]             tail_word,
  output swfd_pkg::frame_chk_t    chk,
  output swfd_pkg::frame_fields_t fields
);
  import swfd_pkg::*;

  psum_t sum9;

  // payload bytes 1..9 sit in cells 11 down to 3
  assign sum9 = sums[11] - sums[2];

  always_comb begin
    fields.device_id         = win[11];
    fields.command           = win[10];
    fields.parameter_res     = {win[8], win[9]};
    fields.device_status     = win[7];
    fields.timestamp         = {win[3], win[4], win[5], win[6]};
    fields.received_checksum = {win[1], win[2]};
    fields.computed_checksum = 16'(sum9);
    chk.hdr_ok  = ({win[13], win[12]} == header_word);
    chk.tail_ok = ({win[0], rx_byte} == tail_word);
    chk.sum_ok  = (fields.received_checksum == fields.computed_checksum);
  end

endmodule

// ===== hdl/sync_word_frame_deframer.sv =====
// header/tail framed packet deframer with 16-bit additive checksum
// latency: a result appears in the cycle after the edge that accepts the closing byte
// throughput: one item per cycle; the byte window is a shift row of cells and
// a result held off by out_tready stalls the input until it is taken
// reset (synchronous, active low) clears fill and bad-frame counts, header, tail and
// output valid, sets limit to 100; window cells and output data are not cleared
module sync_word_frame_deframer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // rx_byte
  input  logic [0:0]                          in_tuser,   // operation
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // device_id, command, parameter_res, device_status, timestamp,
  // received_checksum, computed_checksum
  output logic [swfd_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [1:0]                          out_tuser,  // event_kind
  input  logic                                cfg_we,
  input  logic [swfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swfd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import swfd_pkg::*;

  `include "assert_macros.svh"

  logic [15:0]       header_r;
  logic [15:0]       tail_r;
  logic [7:0]        limit_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [BAD_W-1:0]  bad_r, bad_nxt, bad_inc;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r, out_kind_nxt;
  frame_fields_t     out_data_r, out_data_nxt;

  logic          in_acc, byte_acc, at_eval, over_limit, emit;
  win_t          win;
  sums_t         sums;
  frame_chk_t    chk;
  frame_fields_t fields;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign byte_acc  = in_acc && (in_tuser[0] == OP_BYTE);
  assign at_eval   = byte_acc && (fill_r == FILL_LAST);

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    if (k == 0) begin : g_head
      swfd_cell u_cell (
        .clk      (clk),
        .shift_en (byte_acc),
        .byte_in  (in_tdata),
        .new_byte (in_tdata),
        .sum_in   ('0),
        .byte_out (win[k]),
        .sum_out  (sums[k])
      );
    end else begin : g_body
      swfd_cell u_cell (
        .clk      (clk),
        .shift_en (byte_acc),
        .byte_in  (win[k-1]),
        .new_byte (in_tdata),
        .sum_in   (sums[k-1]),
        .byte_out (win[k]),
        .sum_out  (sums[k])
      );
    end
  end

  swfd_frame_check u_check (
    .win         (win),
    .sums        (sums),
    .rx_byte     (in_tdata),
    .header_word (header_r),
    .tail_word   (tail_r),
    .chk         (chk),
    .fields      (fields)
  );

  assign bad_inc    = bad_r + 1'b1;
  assign over_limit = bad_inc > {1'b0, limit_r};
  assign emit       = at_eval && chk.hdr_ok && (chk.tail_ok || over_limit);

  always_comb begin
    fill_nxt     = fill_r;
    bad_nxt      = bad_r;
    out_kind_nxt = out_kind_r;
    out_data_nxt = out_data_r;
    priority if (in_acc && (in_tuser[0] == OP_TIMEOUT)) begin
      fill_nxt = '0;
    end else if (at_eval) begin
      priority if (!chk.hdr_ok) begin
        fill_nxt = FILL_LAST;
      end else if (chk.tail_ok) begin
        fill_nxt     = '0;
        out_kind_nxt = chk.sum_ok ? KIND_GOOD : KIND_BAD_SUM;
        out_data_nxt = fields;
      end else if (over_limit) begin
        fill_nxt     = '0;
        bad_nxt      = '0;
        out_kind_nxt = KIND_FLUSH;
        out_data_nxt = '0;
      end else begin
        fill_nxt = FILL_DROP2;
        bad_nxt  = bad_inc;
      end
    end else if (byte_acc) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      bad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= '0;
      tail_r   <= '0;
      limit_r  <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER: header_r <= cfg_wdata;
        CFG_TAIL:   tail_r   <= cfg_wdata;
        CFG_LIMIT:  limit_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_data_r;

  `SWFD_ASSERT_ALWAYS(a_fill_range, clk, rst_n, fill_r <= FILL_LAST)
  `SWFD_ASSERT_NEXT(a_timeout_empties, clk, rst_n, in_acc && (in_tuser[0] == OP_TIMEOUT), fill_r == '0)
  `SWFD_ASSERT_NEXT(a_flush_clears_count, clk, rst_n, emit && !chk.tail_ok, (bad_r == '0) && (out_tuser == KIND_FLUSH))
  `SWFD_ASSERT_IMPL(a_flush_zero_payload, clk, rst_n, out_tvalid && (out_tuser == KIND_FLUSH), out_tdata == '0)
  `SWFD_ASSERT_IMPL(a_no_emit_when_blocked, clk, rst_n, emit, in_tready)

endmodule
